// File: rtl/core/spq_pkg.sv
package spq_pkg;

   // Operation codes carried in req_mode
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } spq_status_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic push;
      logic pop;
   } spq_op_type;

endpackage

// File: rtl/core/spq_cell.sv
module spq_cell #(
   parameter int PRIO_BITS = 8,
   parameter int DATA_BITS = 32
) (
   input  logic                 clock,
   input  spq_pkg::spq_op_type  op,
   input  logic                 occupied,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic [DATA_BITS-1:0] new_data,
   input  logic                 left_ins,
   input  logic [PRIO_BITS-1:0] left_prio,
   input  logic [DATA_BITS-1:0] left_data,
   input  logic [PRIO_BITS-1:0] right_prio,
   input  logic [DATA_BITS-1:0] right_data,
   output logic                 ins,
   output logic [PRIO_BITS-1:0] cell_prio,
   output logic [DATA_BITS-1:0] cell_data
);
   import spq_pkg::*;

   logic [PRIO_BITS-1:0] prio_ff;
   logic [PRIO_BITS-1:0] prio_in;
   logic [DATA_BITS-1:0] data_ff;
   logic [DATA_BITS-1:0] data_in;

   // New entry lands at or before this cell: slot empty or strictly beaten
   assign ins = !occupied || (new_prio > prio_ff);

   // Insert: first inserting cell takes the new entry, later ones shift down.
   // Pop: every cell takes its right neighbour.
   always_comb begin
      prio_in = prio_ff;
      data_in = data_ff;
      if (op.push && ins) begin
         if (left_ins) begin
            prio_in = left_prio;
            data_in = left_data;
         end else begin
            prio_in = new_prio;
            data_in = new_data;
         end
      end else if (op.pop) begin
         prio_in = right_prio;
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign cell_prio = prio_ff;
   assign cell_data = data_ff;

endmodule

// File: rtl/core/sorted_priority_queue.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    mode, priority_req, payload
// rsp      out        rsp_valid/rsp_ready    status, out_priority, out_payload, fill
//
// One beat per cycle while rsp is not stalled: every cell compares its entry with the
// pushed priority at once and the whole row shifts together.
// The result sits in an output register; a new beat is taken while it is drained.
// A stalled rsp channel holds off req until the result register frees.
// Reset clears the entry count and the result valid; cell contents are left as is.
module sorted_priority_queue #(
   parameter int DEPTH     = 64,
   parameter int PRIO_BITS = 8,
   parameter int DATA_BITS = 32,
   localparam int CNT_W    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [PRIO_BITS-1:0] req_priority_req,
   input  logic [DATA_BITS-1:0] req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [PRIO_BITS-1:0] rsp_out_priority,
   output logic [DATA_BITS-1:0] rsp_out_payload,
   output logic [CNT_W-1:0]     rsp_fill
);
   import spq_pkg::*;

   logic [CNT_W-1:0]     occ_ff;
   logic [CNT_W-1:0]     occ_in;
   logic                 rsp_valid_ff;
   spq_status_type       status_ff;
   spq_status_type       status_in;
   logic [PRIO_BITS-1:0] out_prio_ff;
   logic [DATA_BITS-1:0] out_data_ff;
   logic [CNT_W-1:0]     fill_ff;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   spq_op_type           op;

   logic [DEPTH-1:0]     occupied;
   logic [DEPTH-1:0]     cell_ins;
   logic [PRIO_BITS-1:0] cell_prio [DEPTH];
   logic [DATA_BITS-1:0] cell_data [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (occ_ff == CNT_W'(DEPTH));
   assign is_empty  = (occ_ff == '0);

   // Decode the beat into a row command and next count
   always_comb begin
      op        = '0;
      occ_in    = occ_ff;
      status_in = STATUS_OK;
      if (req_mode == MODE_PUSH) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end else begin
            op.push = accept;
            if (accept) begin
               occ_in = occ_ff + CNT_W'(1);
            end
         end
      end else begin
         if (is_empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            op.pop = accept;
            if (accept) begin
               occ_in = occ_ff - CNT_W'(1);
            end
         end
      end
   end

   // Row of cells, each linked to both neighbours
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                 l_ins;
      logic [PRIO_BITS-1:0] l_prio;
      logic [DATA_BITS-1:0] l_data;
      logic [PRIO_BITS-1:0] r_prio;
      logic [DATA_BITS-1:0] r_data;

      if (i == 0) begin : g_head
         assign l_ins  = 1'b0;
         assign l_prio = '0;
         assign l_data = '0;
      end else begin : g_body
         assign l_ins  = cell_ins[i-1];
         assign l_prio = cell_prio[i-1];
         assign l_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign r_prio = cell_prio[i];
         assign r_data = cell_data[i];
      end else begin : g_next
         assign r_prio = cell_prio[i+1];
         assign r_data = cell_data[i+1];
      end

      assign occupied[i] = (occ_ff > CNT_W'(i));

      spq_cell #(
         .PRIO_BITS (PRIO_BITS),
         .DATA_BITS (DATA_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .occupied   (occupied[i]),
         .new_prio   (req_priority_req),
         .new_data   (req_payload),
         .left_ins   (l_ins),
         .left_prio  (l_prio),
         .left_data  (l_data),
         .right_prio (r_prio),
         .right_data (r_data),
         .ins        (cell_ins[i]),
         .cell_prio  (cell_prio[i]),
         .cell_data  (cell_data[i])
      );
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_in;
         out_prio_ff <= op.pop ? cell_prio[0] : '0;
         out_data_ff <= op.pop ? cell_data[0] : '0;
         fill_ff     <= occ_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = out_prio_ff;
   assign rsp_out_payload  = out_data_ff;
   assign rsp_fill         = fill_ff;

`ifndef SYNTHESIS
   // Count never runs past the row
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   // Head two entries stay in order
   a_sorted: assert property (@(posedge clock) disable iff (reset)
      occ_ff >= CNT_W'(2) |-> cell_prio[0] >= cell_prio[1])
      else $error("row out of order");

   // A full flag only when the row really was full
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_PUSH && !is_full |=> status_ff != STATUS_FULL)
      else $error("push flagged full below depth");

   // A pop on a non-empty row reports one fewer entry
   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode == MODE_POP && !is_empty
      |=> rsp_fill == $past(occ_ff) - CNT_W'(1))
      else $error("pop fill mismatch");
`endif

endmodule

// File: sim/spq_checker.sv
// Watches both channels of the sorted priority queue, keeps its own sorted copy of the
// stored entries and checks every rsp beat against the oldest predicted result.
module spq_checker #(
   parameter int DEPTH     = 64,
   parameter int PRIO_BITS = 8,
   parameter int DATA_BITS = 32,
   localparam int CNT_W    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_mode,
   input  logic [PRIO_BITS-1:0] req_priority_req,
   input  logic [DATA_BITS-1:0] req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [1:0]           rsp_status,
   input  logic [PRIO_BITS-1:0] rsp_out_priority,
   input  logic [DATA_BITS-1:0] rsp_out_payload,
   input  logic [CNT_W-1:0]     rsp_fill,
   output int                   fail_count,
   output int                   outstanding,
   output int                   push_count,
   output int                   drop_count,
   output int                   pop_count,
   output int                   empty_count
);
   import spq_pkg::*;

   typedef struct {
      spq_status_type       status;
      logic [PRIO_BITS-1:0] prio;
      logic [DATA_BITS-1:0] data;
      logic [CNT_W-1:0]     fill;
   } queue_result_type;

   // shadow of the stored entries, best first
   logic [PRIO_BITS-1:0] shadow_prio [DEPTH];
   logic [DATA_BITS-1:0] shadow_data [DEPTH];
   int                   shadow_count;

   queue_result_type owed_results [$];
   int errors   = 0;
   int n_push   = 0;
   int n_drop   = 0;
   int n_pop    = 0;
   int n_empty  = 0;

   // apply one operation to the shadow queue and return what the block should answer
   function automatic queue_result_type apply_queue_op(logic mode,
                                                       logic [PRIO_BITS-1:0] prio,
                                                       logic [DATA_BITS-1:0] data);
      queue_result_type r;
      int pos;
      r.status = STATUS_OK;
      r.prio   = '0;
      r.data   = '0;
      if (mode == MODE_PUSH) begin
         if (shadow_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            // new entry goes behind every entry of equal or higher priority
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (prio > shadow_prio[i]) begin
                  pos = i;
                  break;
               end
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_prio[i] = shadow_prio[i-1];
               shadow_data[i] = shadow_data[i-1];
            end
            shadow_prio[pos] = prio;
            shadow_data[pos] = data;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.prio = shadow_prio[0];
            r.data = shadow_data[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
               shadow_prio[i] = shadow_prio[i+1];
               shadow_data[i] = shadow_data[i+1];
            end
            shadow_count--;
         end
      end
      r.fill = CNT_W'(shadow_count);
      return r;
   endfunction

   // sample both channels at the edge; req first, so a same-edge rsp still pairs with the oldest
   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         shadow_count = 0;
         owed_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            want = apply_queue_op(req_mode, req_priority_req, req_payload);
            owed_results.push_back(want);
            case (want.status)
               STATUS_FULL:  n_drop++;
               STATUS_EMPTY: n_empty++;
               default: ;
            endcase
            if (req_mode == MODE_PUSH) n_push++;
            else n_pop++;
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, got status %0d fill %0d",
                        $time, rsp_status, rsp_fill);
               errors++;
            end else begin
               want = owed_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_out_priority !== want.prio) begin
                  $display("%0t: out_priority mismatch, expected %0d, got %0d",
                           $time, want.prio, rsp_out_priority);
                  errors++;
               end
               if (rsp_out_payload !== want.data) begin
                  $display("%0t: out_payload mismatch, expected %h, got %h",
                           $time, want.data, rsp_out_payload);
                  errors++;
               end
               if (rsp_fill !== want.fill) begin
                  $display("%0t: fill mismatch, expected %0d, got %0d",
                           $time, want.fill, rsp_fill);
                  errors++;
               end
            end
         end
      end
      // published after the edge so the stimulus side reads them race free
      outstanding <= owed_results.size();
      fail_count  <= errors;
      push_count  <= n_push;
      drop_count  <= n_drop;
      pop_count   <= n_pop;
      empty_count <= n_empty;
   end

endmodule

// File: sim/tb.sv
module tb;
   import spq_pkg::*;

   localparam int DEPTH     = 64;
   localparam int PRIO_BITS = 8;
   localparam int DATA_BITS = 32;
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int PHASE_BEATS = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_mode = MODE_PUSH;
   logic [PRIO_BITS-1:0] req_priority_req = '0;
   logic [DATA_BITS-1:0] req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_status;
   logic [PRIO_BITS-1:0] rsp_out_priority;
   logic [DATA_BITS-1:0] rsp_out_payload;
   logic [CNT_W-1:0]     rsp_fill;

   int fail_count, outstanding, push_count, drop_count, pop_count, empty_count;
   int idle_pct  = 0;
   int stall_pct = 0;

   always #1 clock = ~clock;

   sorted_priority_queue #(
      .DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .DATA_BITS(DATA_BITS)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_priority_req(req_priority_req), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority), .rsp_out_payload(rsp_out_payload),
      .rsp_fill(rsp_fill)
   );

   spq_checker #(
      .DEPTH(DEPTH), .PRIO_BITS(PRIO_BITS), .DATA_BITS(DATA_BITS)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_mode(req_mode),
      .req_priority_req(req_priority_req), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_out_priority(rsp_out_priority), .rsp_out_payload(rsp_out_payload),
      .rsp_fill(rsp_fill),
      .fail_count(fail_count), .outstanding(outstanding),
      .push_count(push_count), .drop_count(drop_count),
      .pop_count(pop_count), .empty_count(empty_count)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // present one req beat, hold it until taken, then idle cycle by cycle at idle_pct
   task automatic send_beat(logic mode, logic [PRIO_BITS-1:0] prio,
                            logic [DATA_BITS-1:0] data);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_priority_req <= prio;
      req_payload      <= data;
      do @(posedge clock); while (!req_ready);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   function automatic logic [PRIO_BITS-1:0] pick_priority();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return PRIO_BITS'($urandom_range(255));
         5, 6:          return ($urandom_range(1) != 0) ? '1 : '0;
         default:       return PRIO_BITS'($urandom_range(3) * 85);
      endcase
   endfunction

   // safety net
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      int push_pct;
      int seg_left;
      logic mode;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pop, extreme fields, ties at top, middle and bottom
      send_beat(MODE_POP,  8'd0,   32'h0);
      send_beat(MODE_PUSH, 8'd255, 32'hffff_ffff);
      send_beat(MODE_PUSH, 8'd0,   32'h0000_0000);
      send_beat(MODE_PUSH, 8'd128, 32'ha5a5_a5a5);
      send_beat(MODE_PUSH, 8'd128, 32'h5a5a_5a5a);
      send_beat(MODE_PUSH, 8'd128, 32'h0000_0001);
      send_beat(MODE_PUSH, 8'd255, 32'h0000_0000);
      send_beat(MODE_PUSH, 8'd1,   32'h0000_0002);
      send_beat(MODE_PUSH, 8'd0,   32'hffff_ffff);
      repeat (8) send_beat(MODE_POP, 8'hff, 32'hffff_ffff);
      send_beat(MODE_POP,  8'd0,   32'h0);
      send_beat(MODE_PUSH, 8'd7,   32'h1234_5678);
      send_beat(MODE_POP,  8'd0,   32'h0);
      send_beat(MODE_POP,  8'd0,   32'h0);

      // random phases: none, sender idle, receiver stall, both lightly
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 55; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 7;  stall_pct = 7;  end
         endcase
         // first segment of the first phase runs the queue past full
         push_pct = 100;
         seg_left = (phase == 0) ? 70 : 0;
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(10, 120);
               case ($urandom_range(2))
                  0:       push_pct = 92;
                  1:       push_pct = 50;
                  default: push_pct = 8;
               endcase
            end
            seg_left--;
            mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
            send_beat(mode, pick_priority(), $urandom());
         end
         // hold the sender off until every result is back
         req_valid <= 1'b0;
         do @(posedge clock); while (outstanding != 0);
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (10) @(posedge clock);

      $display("Ran %0d beats: %0d pushes (%0d dropped on a full queue), %0d pops (%0d empty).",
               push_count + pop_count, push_count, drop_count, pop_count, empty_count);
      $display("Phases covered free flow, sender gaps, receiver stalls and mixed idling.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
